// ----- src/rce_pkg.sv -----
// ----------------------------------------------------------------------------
// Roberts cross edge magnitude package
// Shared types and constants: the control state encoding, the pixel type,
// and the register indexes, width and reset values of the configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rce_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_DONE
   } rce_state_type;

   typedef logic [7:0] pixel_type;

   localparam int unsigned CSR_WIDTH_BITS = 9;

   localparam logic CSR_ACTIVE_WIDTH  = 1'b0;
   localparam logic CSR_ACTIVE_HEIGHT = 1'b1;

   localparam logic [CSR_WIDTH_BITS-1:0] ACTIVE_WIDTH_RESET  = 9'd256;
   localparam logic [CSR_WIDTH_BITS-1:0] ACTIVE_HEIGHT_RESET = 9'd256;

endpackage

// ----- src/roberts_cross_edge_magnitude.sv -----
// ----------------------------------------------------------------------------
// Roberts cross edge magnitude
// Streams grayscale pixels in raster order and returns one saturated
// gradient magnitude per pixel from a 2x2 window with edge replication.
//
//   channel   direction  handshake           payload
//   req       in         req_valid/req_stall req_pixel_in
//   rsp       out        rsp_valid/rsp_stall rsp_edge_value, rsp_end_of_frame
//   csr       in         csr_wr_en           csr_index, csr_wdata
//
// A request passes from acceptance to the result register in this order: the
// line store is read at acceptance, then the gradient step, the squaring
// step, the bit-serial square root and the result load. A new request is
// not accepted until the previous result has been loaded. Reset is
// synchronous and clears the counters and neighbor pixels; the line store
// is not cleared. A stalled result holds the block in its final state
// until the result register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roberts_cross_edge_magnitude
   import rce_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_pixel_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_edge_value,
   output logic                      rsp_end_of_frame,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [CSR_WIDTH_BITS-1:0] csr_wdata
);

   localparam int unsigned CW  = $clog2(MAX_WIDTH);
   localparam int unsigned RW  = $clog2(MAX_HEIGHT);
   localparam int unsigned CWX = (CW + 1 > CSR_WIDTH_BITS) ? CW + 1 : CSR_WIDTH_BITS;
   localparam int unsigned RWX = (RW + 1 > CSR_WIDTH_BITS) ? RW + 1 : CSR_WIDTH_BITS;
   localparam logic [CWX-1:0] MAX_W = CWX'(MAX_WIDTH);
   localparam logic [RWX-1:0] MAX_H = RWX'(MAX_HEIGHT);

   rce_state_type             state_ff, state_in;
   logic [CSR_WIDTH_BITS-1:0] active_width_ff, active_height_ff;
   logic [CW-1:0]             column_count_ff, column_count_in;
   logic [RW-1:0]             row_count_ff, row_count_in;
   pixel_type                 left_pixel_ff, above_left_pixel_ff;
   pixel_type                 cur_ff, rd_data_ff;
   logic [CW-1:0]             item_col_ff;
   logic [RW-1:0]             item_row_ff;
   logic [7:0]                gx_ff, gy_ff;
   logic [16:0]               sum_ff;
   logic [7:0]                root_ff, root_in;
   logic [7:0]                bit_ff;
   logic                      eof_ff, eof_in;
   logic                      rsp_valid_ff;
   logic [7:0]                rsp_edge_value_ff;
   logic                      rsp_eof_ff;
   pixel_type                 line_mem [MAX_WIDTH];

   logic                      req_accept, rsp_load;
   logic [CWX-1:0]            width_eff, col_next;
   logic [RWX-1:0]            height_eff, row_next;
   pixel_type                 up_pix, lf_pix, ul_pix;
   logic [7:0]                gx, gy, trial;
   logic [15:0]               trial_sq;

   assign req_stall        = (state_ff != ST_IDLE);
   assign req_accept       = req_valid && !req_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_edge_value   = rsp_edge_value_ff;
   assign rsp_end_of_frame = rsp_eof_ff;
   assign rsp_load         = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (active_width_ff == '0) begin
         width_eff = CWX'(1);
      end else if (CWX'(active_width_ff) > MAX_W) begin
         width_eff = MAX_W;
      end else begin
         width_eff = CWX'(active_width_ff);
      end
      if (active_height_ff == '0) begin
         height_eff = RWX'(1);
      end else if (RWX'(active_height_ff) > MAX_H) begin
         height_eff = MAX_H;
      end else begin
         height_eff = RWX'(active_height_ff);
      end
      col_next = CWX'(item_col_ff) + CWX'(1);
      row_next = RWX'(item_row_ff) + RWX'(1);
   end

   always_comb begin
      up_pix = (item_row_ff == '0) ? cur_ff : rd_data_ff;
      lf_pix = (item_col_ff == '0) ? cur_ff : left_pixel_ff;
      if (item_row_ff == '0) begin
         ul_pix = lf_pix;
      end else if (item_col_ff == '0) begin
         ul_pix = up_pix;
      end else begin
         ul_pix = above_left_pixel_ff;
      end
      gx = (ul_pix > cur_ff) ? ul_pix - cur_ff : cur_ff - ul_pix;
      gy = (up_pix > lf_pix) ? up_pix - lf_pix : lf_pix - up_pix;
   end

   always_comb begin
      trial    = root_ff | bit_ff;
      trial_sq = trial * trial;
      root_in  = (17'(trial_sq) <= sum_ff) ? trial : root_ff;
   end

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      eof_in          = 1'b0;
      if (col_next >= width_eff) begin
         column_count_in = '0;
         if (row_next >= height_eff) begin
            row_count_in = '0;
            eof_in       = 1'b1;
         end else begin
            row_count_in = RW'(row_next);
         end
      end else begin
         column_count_in = CW'(col_next);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_GRAD;
            end
         end
         ST_GRAD:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ROOT;
         ST_ROOT: begin
            if (bit_ff[0]) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff  <= ACTIVE_WIDTH_RESET;
         active_height_ff <= ACTIVE_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ACTIVE_WIDTH:  active_width_ff  <= csr_wdata;
            CSR_ACTIVE_HEIGHT: active_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= line_mem[column_count_ff];
      end
      if (state_ff == ST_GRAD) begin
         line_mem[item_col_ff] <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff     <= '0;
         row_count_ff        <= '0;
         left_pixel_ff       <= '0;
         above_left_pixel_ff <= '0;
      end else if (state_ff == ST_GRAD) begin
         column_count_ff     <= column_count_in;
         row_count_ff        <= row_count_in;
         left_pixel_ff       <= cur_ff;
         above_left_pixel_ff <= up_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur_ff      <= req_pixel_in;
         item_col_ff <= column_count_ff;
         item_row_ff <= row_count_ff;
      end
      if (state_ff == ST_GRAD) begin
         gx_ff  <= gx;
         gy_ff  <= gy;
         eof_ff <= eof_in;
      end
      if (state_ff == ST_SQUARE) begin
         sum_ff  <= 17'({8'd0, gx_ff} * {8'd0, gx_ff}) + 17'({8'd0, gy_ff} * {8'd0, gy_ff});
         root_ff <= '0;
         bit_ff  <= 8'h80;
      end
      if (state_ff == ST_ROOT) begin
         root_ff <= root_in;
         bit_ff  <= bit_ff >> 1;
      end
      if (rsp_load) begin
         rsp_edge_value_ff <= root_ff;
         rsp_eof_ff        <= eof_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
      end
   end

`ifndef NO_ASSERTIONS
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      CWX'(column_count_ff) < MAX_W)
      else $error("column count beyond line store");

   a_accept_to_grad: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_GRAD))
      else $error("accepted request did not start gradient step");

   a_root_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> $onehot(bit_ff))
      else $error("square root bit mask not one-hot");

   a_eof_wraps: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && eof_ff) |=> (column_count_ff == '0 && row_count_ff == '0))
      else $error("end of frame without counter wrap");
`endif

endmodule
